// ===== src/sbss_pkg.sv =====
// Shared types, codes and helper functions of the separable bilinear scale sequencer.
package sbss_pkg;

   // Widths of the fixed fields.
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned COORD_W = 12;
   localparam int unsigned SIZE_W  = 13;
   localparam int unsigned FMT_W   = 3;
   localparam int unsigned STRIDE_W = 16;
   localparam int unsigned ALPHA_W = 8;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 160;

   // Largest legal area or buffer size.
   localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

   // Request operations.
   localparam logic OP_START = 1'b0;
   localparam logic OP_DONE  = 1'b1;

   // Response kinds.
   localparam logic [KIND_W-1:0] KIND_BLEND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BUSY   = 2'd2;

   // Sequence phases.
   localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_PASS0 = 2'd1;
   localparam logic [PHASE_W-1:0] PH_PASS1 = 2'd2;

   // Pixel formats.
   localparam logic [FMT_W-1:0] FMT_ARGB8888 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGB888   = 3'd1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SRC_BASE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_FORMAT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_BUF_WIDTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_BASE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FORMAT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DST_BASE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DST_FORMAT    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DST_BUF_WIDTH = 3'd7;

   typedef logic [SIZE_W-1:0] size_type;

   // Bytes per pixel; unknown codes count as two bytes.
   function automatic logic [2:0] bytes_per_pixel(input logic [FMT_W-1:0] fmt);
      logic [2:0] bpp;
      if (fmt == FMT_ARGB8888) begin
         bpp = 3'd4;
      end else if (fmt == FMT_RGB888) begin
         bpp = 3'd3;
      end else begin
         bpp = 3'd2;
      end
      return bpp;
   endfunction

   // A size of zero counts as one, anything above the maximum as the maximum.
   function automatic size_type clamp_size(input size_type v);
      size_type r;
      if (v == '0) begin
         r = 13'd1;
      end else if (v > SIZE_MAX) begin
         r = SIZE_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== src/separable_bilinear_scale_sequencer_top.sv =====
// Top level of the separable bilinear scale sequencer: sequencer, shared multiply-add and divider.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser op, tdata source and destination areas
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser kind, tdata blend command fields
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// A start word runs the multiply-add steps for addresses and strides, then a restoring
// divider that yields one quotient bit per cycle. The switch to the column pass also runs the
// divider; a done word with a further command passes the background and output steps, a
// finish or a busy start only the output step. Reset is synchronous and returns the sequence
// to idle. While a word is in work req_tready is low; a stalled response holds the sequencer
// in its last step.
module separable_bilinear_scale_sequencer_top #(
   parameter int unsigned FRACTION_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // Bits up: src_x[11:0], src_y[23:12], src_w[36:24], src_h[49:37], dst_x[61:50],
   // dst_y[73:62], dst_w[86:74], dst_h[99:87], zero fill [103:100].
   input  logic [sbss_pkg::REQ_DATA_W-1:0] req_tdata,
   // Bits up: op[0].
   input  logic         req_tuser,
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Bits up: pass[0], bg_address[32:1], fg_address[64:33], fg_alpha[72:65],
   // out_address[104:73], pixels_per_line[117:105], line_count[130:118],
   // input_skip[142:131], output_skip[154:143], zero fill [159:155].
   output logic [sbss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Bits up: kind[1:0].
   output logic [sbss_pkg::KIND_W-1:0] rsp_tuser,
   // Register write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [sbss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sbss_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned NUM_W = sbss_pkg::COORD_W + FRACTION_BITS;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SPIX    = 4'd1;
   localparam logic [3:0] ST_LBASE   = 4'd2;
   localparam logic [3:0] ST_DPIX    = 4'd3;
   localparam logic [3:0] ST_DSTART  = 4'd4;
   localparam logic [3:0] ST_LSTRIDE = 4'd5;
   localparam logic [3:0] ST_WSTRIDE = 4'd6;
   localparam logic [3:0] ST_DIVSET  = 4'd7;
   localparam logic [3:0] ST_DIV     = 4'd8;
   localparam logic [3:0] ST_BG      = 4'd9;
   localparam logic [3:0] ST_OUT     = 4'd10;

   // Configuration registers.
   logic [31:0] src_base_ff, scale_base_ff, dst_base_ff;
   logic [2:0]  src_format_ff, scale_format_ff, dst_format_ff;
   logic [12:0] src_buf_width_ff, dst_buf_width_ff;

   // Control state.
   logic [3:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Working registers.
   logic [12:0] steps_left_ff, steps_left_in;
   logic [31:0] blend_index_ff, blend_index_in;
   logic [31:0] blend_step_ff, blend_step_in;
   logic [31:0] line_base_ff, line_base_in;
   logic [15:0] line_stride_ff, line_stride_in;
   logic [31:0] write_address_ff, write_address_in;
   logic [15:0] write_stride_ff, write_stride_in;
   logic [31:0] dst_start_ff, dst_start_in;
   logic [12:0] saved_ff [4];
   logic [12:0] saved_in [4];
   logic [11:0] sx_ff, sy_ff, dx_ff, dy_ff;
   logic [11:0] sx_in, sy_in, dx_in, dy_in;
   logic [31:0] mac_ff, mac_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [12:0] rem_ff, rem_in;
   logic [12:0] divisor_ff, divisor_in;
   logic [sbss_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;

   // Shared multiply-add operands.
   logic [31:0] mac_a, mac_c;
   logic [15:0] mac_b;
   logic [47:0] mac_prod;

   // Divider step values.
   logic [13:0] rem_shift;
   logic        rem_ge;

   // Request fields.
   logic        req_op;
   logic [11:0] req_src_x, req_src_y, req_dst_x, req_dst_y;
   logic [12:0] req_src_w, req_src_h, req_dst_w, req_dst_h;
   logic        req_accept;

   // Command field values.
   logic [31:0] cmd_fg;
   logic [7:0]  cmd_alpha;
   logic        cmd_pass;
   logic [12:0] cmd_ppl, cmd_lines;
   logic [11:0] cmd_iskip, cmd_oskip;
   logic [12:0] dbw_clamped;
   logic        out_free;
   logic [12:0] steps_dec;

   assign req_op    = req_tuser;
   assign req_src_x = req_tdata[11:0];
   assign req_src_y = req_tdata[23:12];
   assign req_src_w = req_tdata[36:24];
   assign req_src_h = req_tdata[49:37];
   assign req_dst_x = req_tdata[61:50];
   assign req_dst_y = req_tdata[73:62];
   assign req_dst_w = req_tdata[86:74];
   assign req_dst_h = req_tdata[99:87];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign steps_dec  = steps_left_ff - 13'd1;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff      <= '0;
         src_format_ff    <= '0;
         src_buf_width_ff <= 13'd320;
         scale_base_ff    <= '0;
         scale_format_ff  <= '0;
         dst_base_ff      <= '0;
         dst_format_ff    <= '0;
         dst_buf_width_ff <= 13'd480;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sbss_pkg::REG_SRC_BASE:      src_base_ff      <= csr_data;
            sbss_pkg::REG_SRC_FORMAT:    src_format_ff    <= csr_data[2:0];
            sbss_pkg::REG_SRC_BUF_WIDTH: src_buf_width_ff <= csr_data[12:0];
            sbss_pkg::REG_SCALE_BASE:    scale_base_ff    <= csr_data;
            sbss_pkg::REG_SCALE_FORMAT:  scale_format_ff  <= csr_data[2:0];
            sbss_pkg::REG_DST_BASE:      dst_base_ff      <= csr_data;
            sbss_pkg::REG_DST_FORMAT:    dst_format_ff    <= csr_data[2:0];
            sbss_pkg::REG_DST_BUF_WIDTH: dst_buf_width_ff <= csr_data[12:0];
         endcase
      end
   end

   // Shared multiply-add: operands chosen by the sequencer step.
   always_comb begin
      mac_a = '0;
      mac_b = '0;
      mac_c = '0;
      unique case (state_ff)
         ST_SPIX: begin
            mac_a = 32'(sy_ff);
            mac_b = 16'(src_buf_width_ff);
            mac_c = 32'(sx_ff);
         end
         ST_LBASE: begin
            mac_a = mac_ff;
            mac_b = 16'(sbss_pkg::bytes_per_pixel(src_format_ff));
            mac_c = src_base_ff;
         end
         ST_DPIX: begin
            mac_a = 32'(dy_ff);
            mac_b = 16'(dst_buf_width_ff);
            mac_c = 32'(dx_ff);
         end
         ST_DSTART: begin
            mac_a = mac_ff;
            mac_b = 16'(sbss_pkg::bytes_per_pixel(dst_format_ff));
            mac_c = dst_base_ff;
         end
         ST_LSTRIDE: begin
            mac_a = 32'(src_buf_width_ff);
            mac_b = 16'(sbss_pkg::bytes_per_pixel(src_format_ff));
         end
         ST_WSTRIDE: begin
            mac_a = 32'(saved_ff[0]);
            mac_b = 16'(sbss_pkg::bytes_per_pixel(scale_format_ff));
         end
         ST_BG: begin
            mac_a = 32'(blend_index_ff[31:FRACTION_BITS]);
            mac_b = line_stride_ff;
            mac_c = line_base_ff;
         end
         ST_OUT: begin
            // The background address stays put while the response waits.
            mac_c = mac_ff;
         end
         default: begin
            mac_a = '0;
         end
      endcase
   end

   assign mac_prod = mac_a * mac_b;
   assign mac_in   = mac_prod[31:0] + mac_c;

   // One restoring division step: shift in the next dividend bit and try the divisor.
   assign rem_shift = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, divisor_ff});

   // Command fields from the working state.
   assign dbw_clamped = sbss_pkg::clamp_size(dst_buf_width_ff);
   assign cmd_fg      = mac_ff + 32'(line_stride_ff);
   assign cmd_alpha   = blend_index_ff[FRACTION_BITS-1 -: 8];
   assign cmd_pass    = (phase_ff == sbss_pkg::PH_PASS1);
   assign cmd_ppl     = cmd_pass ? 13'd1 : saved_ff[0];
   assign cmd_lines   = cmd_pass ? saved_ff[3] : 13'd1;
   assign cmd_iskip   = cmd_pass ? 12'(saved_ff[0] - 13'd1) : 12'd0;
   assign cmd_oskip   = cmd_pass ? 12'(dbw_clamped - 13'd1) : 12'd0;

   // Sequencer.
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      kind_in          = kind_ff;
      rsp_valid_in     = rsp_valid_ff;
      div_cnt_in       = div_cnt_ff;
      steps_left_in    = steps_left_ff;
      blend_index_in   = blend_index_ff;
      blend_step_in    = blend_step_ff;
      line_base_in     = line_base_ff;
      line_stride_in   = line_stride_ff;
      write_address_in = write_address_ff;
      write_stride_in  = write_stride_ff;
      dst_start_in     = dst_start_ff;
      saved_in         = saved_ff;
      sx_in            = sx_ff;
      sy_in            = sy_ff;
      dx_in            = dx_ff;
      dy_in            = dy_ff;
      num_in           = num_ff;
      rem_in           = rem_ff;
      divisor_in       = divisor_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_kind_in      = rsp_kind_ff;

      // The response register empties when its word is taken.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               priority if (req_op == sbss_pkg::OP_START) begin
                  if (phase_ff != sbss_pkg::PH_IDLE) begin
                     kind_in  = sbss_pkg::KIND_BUSY;
                     state_in = ST_OUT;
                  end else begin
                     sx_in       = req_src_x;
                     sy_in       = req_src_y;
                     dx_in       = req_dst_x;
                     dy_in       = req_dst_y;
                     saved_in[0] = sbss_pkg::clamp_size(req_src_w);
                     saved_in[1] = sbss_pkg::clamp_size(req_src_h);
                     saved_in[2] = sbss_pkg::clamp_size(req_dst_w);
                     saved_in[3] = sbss_pkg::clamp_size(req_dst_h);
                     kind_in     = sbss_pkg::KIND_BLEND;
                     state_in    = ST_SPIX;
                  end
               end else if (phase_ff == sbss_pkg::PH_IDLE) begin
                  // A done word while idle is dropped.
                  state_in = ST_IDLE;
               end else if (steps_dec != '0) begin
                  steps_left_in    = steps_dec;
                  write_address_in = write_address_ff + 32'(write_stride_ff);
                  blend_index_in   = blend_index_ff + blend_step_ff;
                  kind_in          = sbss_pkg::KIND_BLEND;
                  state_in         = ST_BG;
               end else if (phase_ff == sbss_pkg::PH_PASS0) begin
                  // Switch to the column pass over the scale buffer.
                  phase_in         = sbss_pkg::PH_PASS1;
                  steps_left_in    = saved_ff[2];
                  line_stride_in   = 16'(sbss_pkg::bytes_per_pixel(scale_format_ff));
                  write_stride_in  = 16'(sbss_pkg::bytes_per_pixel(dst_format_ff));
                  line_base_in     = scale_base_ff;
                  write_address_in = dst_start_ff;
                  num_in           = {12'(saved_ff[0] - 13'd1), {FRACTION_BITS{1'b0}}};
                  rem_in           = '0;
                  divisor_in       = saved_ff[2];
                  div_cnt_in       = CNT_W'(NUM_W);
                  kind_in          = sbss_pkg::KIND_BLEND;
                  state_in         = ST_DIV;
               end else begin
                  steps_left_in = steps_dec;
                  phase_in      = sbss_pkg::PH_IDLE;
                  kind_in       = sbss_pkg::KIND_FINISH;
                  state_in      = ST_OUT;
               end
            end
         end
         ST_SPIX: begin
            state_in = ST_LBASE;
         end
         ST_LBASE: begin
            state_in = ST_DPIX;
         end
         ST_DPIX: begin
            line_base_in = mac_ff;
            state_in     = ST_DSTART;
         end
         ST_DSTART: begin
            state_in = ST_LSTRIDE;
         end
         ST_LSTRIDE: begin
            dst_start_in = mac_ff;
            state_in     = ST_WSTRIDE;
         end
         ST_WSTRIDE: begin
            line_stride_in = mac_ff[15:0];
            state_in       = ST_DIVSET;
         end
         ST_DIVSET: begin
            // Line pass: step from source height to destination height.
            write_stride_in  = mac_ff[15:0];
            write_address_in = scale_base_ff;
            steps_left_in    = saved_ff[3];
            phase_in         = sbss_pkg::PH_PASS0;
            num_in           = {12'(saved_ff[1] - 13'd1), {FRACTION_BITS{1'b0}}};
            rem_in           = '0;
            divisor_in       = saved_ff[3];
            div_cnt_in       = CNT_W'(NUM_W);
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               blend_step_in  = 32'(num_ff);
               blend_index_in = 32'(num_ff) >> 1;
               state_in       = ST_BG;
            end else begin
               num_in     = {num_ff[NUM_W-2:0], rem_ge};
               rem_in     = rem_ge ? 13'(rem_shift - {1'b0, divisor_ff}) : rem_shift[12:0];
               div_cnt_in = div_cnt_ff - CNT_W'(1);
            end
         end
         ST_BG: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               if (kind_ff == sbss_pkg::KIND_BLEND) begin
                  rsp_data_in = {5'd0, cmd_oskip, cmd_iskip, cmd_lines, cmd_ppl,
                                 write_address_ff, cmd_alpha, cmd_fg, mac_ff, cmd_pass};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= sbss_pkg::PH_IDLE;
         kind_ff       <= sbss_pkg::KIND_BLEND;
         rsp_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
         steps_left_ff <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_cnt_ff    <= div_cnt_in;
         steps_left_ff <= steps_left_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      blend_index_ff   <= blend_index_in;
      blend_step_ff    <= blend_step_in;
      line_base_ff     <= line_base_in;
      line_stride_ff   <= line_stride_in;
      write_address_ff <= write_address_in;
      write_stride_ff  <= write_stride_in;
      dst_start_ff     <= dst_start_in;
      saved_ff         <= saved_in;
      sx_ff            <= sx_in;
      sy_ff            <= sy_in;
      dx_ff            <= dx_in;
      dy_ff            <= dy_in;
      mac_ff           <= mac_in;
      num_ff           <= num_in;
      rem_ff           <= rem_in;
      divisor_ff       <= divisor_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_kind_ff      <= rsp_kind_in;
   end

endmodule
